FILE: sv/u8l9_pkg.sv
// Shared types, constants and the Latin-9 map for the UTF-8 to Latin-9 decoder.
`default_nettype none

package u8l9_pkg;

    localparam int BYTE_W  = 8;
    localparam int ACCUM_W = 31;
    localparam int PEND_W  = 3;
    localparam int OCNT_W  = 16;

    localparam logic [OCNT_W-1:0] OCNT_MAX = 16'hFFFF;

    // Latin-9 code points outside the first 256 and their bytes
    localparam logic [ACCUM_W-1:0] CP_OE_CAP    = 31'h0152;
    localparam logic [ACCUM_W-1:0] CP_OE_SMALL  = 31'h0153;
    localparam logic [ACCUM_W-1:0] CP_S_CARON_C = 31'h0160;
    localparam logic [ACCUM_W-1:0] CP_S_CARON_S = 31'h0161;
    localparam logic [ACCUM_W-1:0] CP_Y_DIAER_C = 31'h0178;
    localparam logic [ACCUM_W-1:0] CP_Z_CARON_C = 31'h017D;
    localparam logic [ACCUM_W-1:0] CP_Z_CARON_S = 31'h017E;
    localparam logic [ACCUM_W-1:0] CP_EURO      = 31'h20AC;

    localparam logic [BYTE_W-1:0] L9_OE_CAP    = 8'hBC;
    localparam logic [BYTE_W-1:0] L9_OE_SMALL  = 8'hBD;
    localparam logic [BYTE_W-1:0] L9_S_CARON_C = 8'hA6;
    localparam logic [BYTE_W-1:0] L9_S_CARON_S = 8'hA8;
    localparam logic [BYTE_W-1:0] L9_Y_DIAER_C = 8'hBE;
    localparam logic [BYTE_W-1:0] L9_Z_CARON_C = 8'hB4;
    localparam logic [BYTE_W-1:0] L9_Z_CARON_S = 8'hB8;
    localparam logic [BYTE_W-1:0] L9_EURO      = 8'hA4;

    typedef struct packed {
        logic [PEND_W-1:0]  pending;
        logic [ACCUM_W-1:0] accum;
        logic               seq_ok;
    } dec_state_t;

    localparam dec_state_t DEC_STATE_RESET = '{pending: '0, accum: '0, seq_ok: 1'b1};

    typedef struct packed {
        logic [BYTE_W-1:0] latin_byte;
        logic              is_end;
        logic [OCNT_W-1:0] out_count;
    } result_t;

    typedef struct packed {
        logic              hit;
        logic [BYTE_W-1:0] byte_val;
    } map_t;

    function automatic map_t map_latin9(input logic [ACCUM_W-1:0] cp);
        map_t m;
        m.hit      = 1'b1;
        m.byte_val = cp[BYTE_W-1:0];
        if (cp[ACCUM_W-1:BYTE_W] != '0) begin
            unique case (cp)
                CP_OE_CAP:    m.byte_val = L9_OE_CAP;
                CP_OE_SMALL:  m.byte_val = L9_OE_SMALL;
                CP_S_CARON_C: m.byte_val = L9_S_CARON_C;
                CP_S_CARON_S: m.byte_val = L9_S_CARON_S;
                CP_Y_DIAER_C: m.byte_val = L9_Y_DIAER_C;
                CP_Z_CARON_C: m.byte_val = L9_Z_CARON_C;
                CP_Z_CARON_S: m.byte_val = L9_Z_CARON_S;
                CP_EURO:      m.byte_val = L9_EURO;
                default: begin
                    m.hit      = 1'b0;
                    m.byte_val = '0;
                end
            endcase
        end
        return m;
    endfunction

endpackage

`default_nettype wire

FILE: sv/u8l9_step.sv
// Per-byte decode step: next sequence state, output count and the results of one item.
`default_nettype none

module u8l9_step import u8l9_pkg::*; #(
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic [BYTE_W-1:0]      data_byte,
    input  wire logic                   last,
    input  wire logic                   no_data,
    input  wire dec_state_t             st,
    input  wire logic [COUNT_WIDTH-1:0] count,
    output dec_state_t                  st_next,
    output logic [COUNT_WIDTH-1:0]      count_next,
    output logic                        emit_data,
    output logic                        emit_end,
    output result_t                     data_res,
    output result_t                     end_res
);

    localparam int EXT_W = 33;

    logic [BYTE_W-1:0]      data_val;
    logic [ACCUM_W-1:0]     acc_shift;
    logic                   cont_ok;
    logic [PEND_W-1:0]      pend_dec;
    map_t                   mapped;
    logic [COUNT_WIDTH-1:0] count_after;
    logic [EXT_W-1:0]       count_ext;

    assign acc_shift = {st.accum[ACCUM_W-7:0], data_byte[5:0]};
    assign cont_ok   = st.seq_ok & (data_byte[7:6] == 2'b10);
    assign pend_dec  = st.pending - PEND_W'(1);
    assign mapped    = map_latin9(acc_shift);

    always_comb begin
        st_next   = st;
        emit_data = 1'b0;
        data_val  = data_byte;
        if (!no_data) begin
            if (st.pending != '0) begin
                st_next.pending = pend_dec;
                st_next.accum   = acc_shift;
                st_next.seq_ok  = cont_ok;
                if (pend_dec == '0) begin
                    emit_data = cont_ok & mapped.hit;
                    data_val  = mapped.byte_val;
                    st_next   = DEC_STATE_RESET;
                end
            end else begin
                // open a sequence on a lead byte; drop stray continuations and FE/FF
                priority if (data_byte[7] == 1'b0) begin
                    emit_data = 1'b1;
                end else if (data_byte[7:6] == 2'b10) begin
                end else if (data_byte[7:5] == 3'b110) begin
                    st_next = '{pending: 3'd1, accum: ACCUM_W'(data_byte[4:0]), seq_ok: 1'b1};
                end else if (data_byte[7:4] == 4'b1110) begin
                    st_next = '{pending: 3'd2, accum: ACCUM_W'(data_byte[3:0]), seq_ok: 1'b1};
                end else if (data_byte[7:3] == 5'b11110) begin
                    st_next = '{pending: 3'd3, accum: ACCUM_W'(data_byte[2:0]), seq_ok: 1'b1};
                end else if (data_byte[7:2] == 6'b111110) begin
                    st_next = '{pending: 3'd4, accum: ACCUM_W'(data_byte[1:0]), seq_ok: 1'b1};
                end else if (data_byte[7:1] == 7'b1111110) begin
                    st_next = '{pending: 3'd5, accum: ACCUM_W'(data_byte[0]), seq_ok: 1'b1};
                end else begin
                end
            end
        end
        if (last) begin
            st_next = DEC_STATE_RESET;
        end
    end

    // saturate at all ones
    assign count_after = (emit_data && (count != '1)) ? count + COUNT_WIDTH'(1) : count;
    assign count_next  = last ? '0 : count_after;
    assign count_ext   = {{(EXT_W-COUNT_WIDTH){1'b0}}, count_after};

    assign emit_end = last;

    assign data_res = '{latin_byte: data_val, is_end: 1'b0, out_count: '0};
    assign end_res  = '{latin_byte: '0, is_end: 1'b1,
                        out_count: (count_ext > EXT_W'(OCNT_MAX)) ? OCNT_MAX
                                                                : count_ext[OCNT_W-1:0]};

endmodule

`default_nettype wire

FILE: sv/u8l9_resq.sv
// Four-entry result queue taking up to two results per cycle and giving one.
`default_nettype none

module u8l9_resq import u8l9_pkg::*; (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    push0,
    input  wire logic    push1,
    input  wire result_t wr0,
    input  wire result_t wr1,
    output logic         room2,
    output logic         m_valid,
    input  wire logic    m_ready,
    output result_t      m_res
);

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = PTR_W + 1;

    result_t          entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             pop;
    logic [CNT_W-1:0] push_n;
    logic [PTR_W-1:0] wr_ptr_p1;

    assign pop       = m_valid & m_ready;
    assign push_n    = CNT_W'(push0) + CNT_W'(push1);
    assign wr_ptr_p1 = wr_ptr_reg + PTR_W'(1);

    assign wr_ptr_next = wr_ptr_reg + push_n[PTR_W-1:0];
    assign rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
    assign cnt_next    = cnt_reg + push_n - CNT_W'(pop);

    assign room2   = (cnt_reg <= CNT_W'(DEPTH - 2));
    assign m_valid = (cnt_reg != '0);
    assign m_res   = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push0) begin
            entry_reg[wr_ptr_reg] <= wr0;
        end
        if (push0 && push1) begin
            entry_reg[wr_ptr_p1] <= wr1;
        end
    end

endmodule

`default_nettype wire

FILE: sv/utf8_to_latin9_decoder.sv
// UTF-8 to ISO-8859-15 stream decoder top level.
// Path: an input transaction passes the input register, then the four-entry result queue.
// Throughput: one byte per cycle while the queue has room for two; an item ending the text
// with a decoded byte yields two results, which drain one per cycle while m_ready is high.
// Reset: synchronous active-low aresetn clears sequence state, the byte count and queue.
`default_nettype none

module utf8_to_latin9_decoder import u8l9_pkg::*; #(
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [BYTE_W-1:0] s_data_byte,
    input  wire logic              s_last,
    input  wire logic              s_no_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [BYTE_W-1:0]      m_latin_byte,
    output logic                   m_is_end,
    output logic [OCNT_W-1:0]      m_out_count
);

    logic                   in_valid_reg;
    logic [BYTE_W-1:0]      in_byte_reg;
    logic                   in_last_reg;
    logic                   in_nodata_reg;

    dec_state_t             st_reg, st_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;

    logic    emit_data, emit_end;
    result_t data_res, end_res;
    logic    room2, advance;
    result_t m_res;

    assign advance = in_valid_reg & room2;
    assign s_ready = ~in_valid_reg | advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            st_reg       <= DEC_STATE_RESET;
            count_reg    <= '0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                st_reg    <= st_next;
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg   <= s_data_byte;
            in_last_reg   <= s_last;
            in_nodata_reg <= s_no_data;
        end
    end

    u8l9_step #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_step (
        .data_byte (in_byte_reg),
        .last      (in_last_reg),
        .no_data   (in_nodata_reg),
        .st        (st_reg),
        .count     (count_reg),
        .st_next   (st_next),
        .count_next(count_next),
        .emit_data (emit_data),
        .emit_end  (emit_end),
        .data_res  (data_res),
        .end_res   (end_res)
    );

    // data result goes ahead of the terminator
    u8l9_resq u_resq (
        .aclk   (aclk),
        .aresetn(aresetn),
        .push0  (advance & (emit_data | emit_end)),
        .push1  (advance & emit_data & emit_end),
        .wr0    (emit_data ? data_res : end_res),
        .wr1    (end_res),
        .room2  (room2),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_res  (m_res)
    );

    assign m_latin_byte = m_res.latin_byte;
    assign m_is_end     = m_res.is_end;
    assign m_out_count  = m_res.out_count;

endmodule

`default_nettype wire
